// ----- rtl/core/uce_pkg.sv -----
// Shared types, constants and calendar helper functions for the civil time converter.
package uce_pkg;

  localparam int unsigned EPOCH_YEAR     = 1970;
  localparam int unsigned LAST_YEAR      = 2037;
  localparam int unsigned MS_PER_MINUTE  = 60000;
  localparam int unsigned MS_PER_HOUR    = 3600000;
  localparam int unsigned MS_PER_DAY     = 86400000;
  localparam int unsigned MS_PER_MIN_MAX = 59999;
  localparam int unsigned EPOCH_DOW      = 4;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MINUTE_W = 6;
  localparam int unsigned MILLI_W  = 16;
  localparam int unsigned EPOCH_W  = 41;
  localparam int unsigned DOY_W    = 9;
  localparam int unsigned DOW_W    = 3;
  localparam int unsigned OPA_W    = 16;
  localparam int unsigned OPB_W    = 27;
  localparam int unsigned PROD_W   = OPA_W + OPB_W;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  typedef struct packed {
    logic [MILLI_W-1:0]  milli_of_minute;
    logic [MINUTE_W-1:0] minute;
    logic [HOUR_W-1:0]   hour;
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
  } in_item_t;

  typedef struct packed {
    logic             vld;
    logic             clr;
    logic [OPA_W-1:0] a;
    logic [OPB_W-1:0] b;
  } alu_op_t;

  typedef struct packed {
    logic               vld;
    logic               ok;
    logic [EPOCH_W-1:0] epoch_millis;
    logic [DOY_W-1:0]   day_of_year;
    logic [DOW_W-1:0]   day_of_week;
  } res_t;

  // Within the accepted year range the century exceptions never apply, except 2000,
  // which is divisible by 400 and therefore leap, so divisibility by four decides.
  function automatic logic leap_of(input logic [YEAR_W-1:0] y);
    return (y[1:0] == 2'd0);
  endfunction

  function automatic logic [DOY_W-1:0] cum_days(input logic leap,
                                                input logic [MONTH_W-1:0] idx);
    logic [DOY_W-1:0] d;
    unique case (idx)
      4'd0:    d = 9'd31;
      4'd1:    d = 9'd59;
      4'd2:    d = 9'd90;
      4'd3:    d = 9'd120;
      4'd4:    d = 9'd151;
      4'd5:    d = 9'd181;
      4'd6:    d = 9'd212;
      4'd7:    d = 9'd243;
      4'd8:    d = 9'd273;
      4'd9:    d = 9'd304;
      4'd10:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && (idx != 4'd0) && (idx <= 4'd10)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

  function automatic logic [DOW_W-1:0] add_mod7(input logic [DOW_W-1:0] a,
                                                input logic [DOW_W-1:0] b);
    logic [DOW_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[DOW_W-1:0];
  endfunction

  // Folds powers of two that are one modulo seven, then finishes with two subtracts.
  function automatic logic [DOW_W-1:0] mod7_9(input logic [DOY_W-1:0] v);
    logic [6:0] s1;
    logic [3:0] s2;
    s1 = {4'd0, v[8:6]} + {1'b0, v[5:0]};
    s2 = {1'b0, s1[2:0]} + s1[6:3];
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[DOW_W-1:0];
  endfunction

endpackage

// ----- rtl/core/uce_alu.sv -----
// Shared multiply-accumulate unit with a registered product stage.
module uce_alu (
  input  logic                            clk,
  input  logic                            rst_n,
  input  uce_pkg::alu_op_t                op,
  output logic [uce_pkg::EPOCH_W-1:0]     acc
);
  import uce_pkg::*;

  logic [PROD_W-1:0]  prod_r;
  logic               pvld_r;
  logic               pclr_r;
  logic [EPOCH_W-1:0] acc_r;
  logic [EPOCH_W-1:0] acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (pvld_r) begin
      acc_nxt = (pclr_r ? '0 : acc_r) + prod_r[EPOCH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      pclr_r <= 1'b0;
    end else begin
      pvld_r <= op.vld;
      pclr_r <= op.clr;
    end
    prod_r <= op.a * op.b;
    acc_r  <= acc_nxt;
  end

  assign acc = acc_r;

  a_clr_needs_vld: assert property (@(posedge clk) disable iff (!rst_n)
    op.clr |-> op.vld) else $error("accumulator clear issued without an operation");

endmodule

// ----- rtl/core/uce_ctl.sv -----
// Sequencer that checks fields, sums years and scales the day count through the shared unit.
module uce_ctl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  uce_pkg::in_item_t            in_item,
  output uce_pkg::alu_op_t             op,
  input  logic [uce_pkg::EPOCH_W-1:0]  acc,
  output uce_pkg::res_t                res,
  input  logic                         res_rdy
);
  import uce_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_YEARS, S_INYEAR, S_DRAIN_A, S_DAYS, S_MILLI, S_MIN, S_HOUR, S_DRAIN_B, S_FIN
  } state_t;

  state_t              state_r, state_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [YEAR_W-1:0]   y_r, y_nxt;
  logic [MILLI_W-1:0]  milli_r, milli_nxt;
  logic [MINUTE_W-1:0] minute_r, minute_nxt;
  logic [HOUR_W-1:0]   hour_r, hour_nxt;
  logic [DOY_W-1:0]    in_year_r, in_year_nxt;
  logic [DOW_W-1:0]    iy7_r, iy7_nxt;
  logic [DOW_W-1:0]    dowy_r, dowy_nxt;
  logic                ok_r, ok_nxt;
  logic                in_ok;
  logic [DOY_W-1:0]    in_cum;
  logic                y_leap;
  logic [DOW_W-1:0]    dow_sum;

  assign in_ok = (in_item.year >= YEAR_W'(EPOCH_YEAR)) && (in_item.year <= YEAR_W'(LAST_YEAR)) &&
                 (in_item.month >= 4'd1) && (in_item.month <= 4'd12) &&
                 (in_item.day != 5'd0) &&
                 (in_item.hour <= 5'd23) && (in_item.minute <= 6'd59) &&
                 (in_item.milli_of_minute <= MILLI_W'(MS_PER_MIN_MAX));

  assign in_cum = (in_item.month > 4'd1) ?
                  cum_days(leap_of(in_item.year), in_item.month - 4'd2) : '0;
  assign y_leap = leap_of(y_r);
  assign in_rdy = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    year_nxt    = year_r;
    y_nxt       = y_r;
    milli_nxt   = milli_r;
    minute_nxt  = minute_r;
    hour_nxt    = hour_r;
    in_year_nxt = in_year_r;
    iy7_nxt     = iy7_r;
    dowy_nxt    = dowy_r;
    ok_nxt      = ok_r;
    op          = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_vld) begin
          year_nxt    = in_item.year;
          y_nxt       = YEAR_W'(EPOCH_YEAR);
          milli_nxt   = in_item.milli_of_minute;
          minute_nxt  = in_item.minute;
          hour_nxt    = in_item.hour;
          in_year_nxt = in_cum + {4'd0, in_item.day} - 9'd1;
          iy7_nxt     = mod7_9(in_cum + {4'd0, in_item.day} - 9'd1);
          dowy_nxt    = '0;
          ok_nxt      = in_ok;
          state_nxt   = in_ok ? S_YEARS : S_FIN;
        end
      end
      S_YEARS: begin
        if (y_r == year_r) begin
          state_nxt = S_INYEAR;
        end else begin
          op.vld   = 1'b1;
          op.clr   = (y_r == YEAR_W'(EPOCH_YEAR));
          op.a     = OPA_W'(365) + OPA_W'(y_leap);
          op.b     = OPB_W'(1);
          y_nxt    = y_r + 12'd1;
          dowy_nxt = add_mod7(dowy_r, 3'd1 + DOW_W'(y_leap));
        end
      end
      S_INYEAR: begin
        op.vld    = 1'b1;
        op.clr    = (year_r == YEAR_W'(EPOCH_YEAR));
        op.a      = OPA_W'(in_year_r);
        op.b      = OPB_W'(1);
        state_nxt = S_DRAIN_A;
      end
      S_DRAIN_A: state_nxt = S_DAYS;
      S_DAYS: begin
        op.vld    = 1'b1;
        op.clr    = 1'b1;
        op.a      = acc[OPA_W-1:0];
        op.b      = OPB_W'(MS_PER_DAY);
        state_nxt = S_MILLI;
      end
      S_MILLI: begin
        op.vld    = 1'b1;
        op.a      = milli_r;
        op.b      = OPB_W'(1);
        state_nxt = S_MIN;
      end
      S_MIN: begin
        op.vld    = 1'b1;
        op.a      = OPA_W'(minute_r);
        op.b      = OPB_W'(MS_PER_MINUTE);
        state_nxt = S_HOUR;
      end
      S_HOUR: begin
        op.vld    = 1'b1;
        op.a      = OPA_W'(hour_r);
        op.b      = OPB_W'(MS_PER_HOUR);
        state_nxt = S_DRAIN_B;
      end
      S_DRAIN_B: state_nxt = S_FIN;
      S_FIN: begin
        if (res_rdy) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign dow_sum = add_mod7(add_mod7(dowy_r, iy7_r), DOW_W'(EPOCH_DOW));

  always_comb begin
    res              = '0;
    res.vld          = (state_r == S_FIN);
    res.ok           = ok_r;
    if (ok_r) begin
      res.epoch_millis = acc;
      res.day_of_year  = in_year_r + 9'd1;
      res.day_of_week  = dow_sum + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ok_r    <= ok_nxt;
    end
    year_r    <= year_nxt;
    y_r       <= y_nxt;
    milli_r   <= milli_nxt;
    minute_r  <= minute_nxt;
    hour_r    <= hour_nxt;
    in_year_r <= in_year_nxt;
    iy7_r     <= iy7_nxt;
    dowy_r    <= dowy_nxt;
  end

  a_year_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_YEARS) |-> (y_r <= year_r) && (year_r <= YEAR_W'(LAST_YEAR)))
    else $error("year loop ran past the requested year");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld && in_rdy) |=> !in_rdy) else $error("accepted a transaction without going busy");

  a_dow_range: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res.ok) |-> (res.day_of_week != 3'd0) && (res.day_of_year != 9'd0))
    else $error("valid result with zero calendar fields");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && !res.ok) |-> (res.epoch_millis == '0) && (res.day_of_week == 3'd0))
    else $error("invalid result carries nonzero fields");

endmodule

// ----- rtl/core/utc_civil_to_epoch_millis_core.sv -----
// Top level of the UTC civil time to epoch milliseconds converter.
//
// The input stream carries one civil UTC time per transaction; each produces one
// result transaction with milliseconds since 1970-01-01, day of year and day of week
// (1 is Sunday), and a flag in out_tuser that is set when every field was in range.
// An out-of-range field gives all zero fields with the flag clear.
// One transaction is processed at a time. After acceptance the sequencer sums the days
// of each year from 1970 up to the requested year in the shared multiply-accumulate
// unit, then adds the day offset within the year and scales the days and the time
// fields to milliseconds. A new transaction is taken the cycle after the result moves
// into the output register. An invalid input skips the arithmetic and goes straight
// to its result.
// When the receiver stalls, the finished result waits in the output register and the
// sequencer holds its own result until that register frees up; in_tready stays low.
// Reset returns the sequencer to idle and drops out_tvalid; no clearing pass is needed.
module utc_civil_to_epoch_millis_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year, month, day, hour, minute, milli_of_minute
  input  logic [uce_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // epoch_millis, day_of_year, day_of_week, zero fill
  output logic [uce_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // valid_res
  output logic                                out_tuser
);
  import uce_pkg::*;

  in_item_t           in_item;
  alu_op_t            op;
  logic [EPOCH_W-1:0] acc;
  res_t               res;
  logic               res_rdy;
  logic               out_tvalid_r;
  logic [EPOCH_W-1:0] epoch_r;
  logic [DOY_W-1:0]   doy_r;
  logic [DOW_W-1:0]   dow_r;
  logic               okf_r;

  assign in_item = in_tdata;
  assign res_rdy = !out_tvalid_r || out_tready;

  uce_ctl u_ctl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_tvalid),
    .in_rdy  (in_tready),
    .in_item (in_item),
    .op      (op),
    .acc     (acc),
    .res     (res),
    .res_rdy (res_rdy)
  );

  uce_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .op    (op),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (res.vld && res_rdy) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
    if (res.vld && res_rdy) begin
      epoch_r <= res.epoch_millis;
      doy_r   <= res.day_of_year;
      dow_r   <= res.day_of_week;
      okf_r   <= res.ok;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'd0, dow_r, doy_r, epoch_r};
  assign out_tuser  = okf_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (res.vld && res_rdy) |=> out_tvalid_r) else $error("loaded result not presented");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !(res.vld && res_rdy))
    else $error("pending result overwritten");

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the UTC civil time to epoch milliseconds converter.
module tb_top;
  import uce_pkg::*;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch_millis;
    logic [DOY_W-1:0]   day_of_year;
    logic [DOW_W-1:0]   day_of_week;
    logic               in_range;
  } civil_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  civil_result_t pending_results[$];
  civil_result_t expected_now;
  int unsigned   mismatch_count = 0;
  int unsigned   ready_left     = 0;
  int unsigned   ready_roll;
  bit            sender_free    = 1'b0;
  bit            stall_free     = 1'b0;

  utc_civil_to_epoch_millis_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #4 clk = ~clk;

  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  function automatic civil_result_t predict_epoch_result(input in_item_t t);
    civil_result_t     r;
    int unsigned       yr;
    int unsigned       doy0;
    longint unsigned   days;
    longint unsigned   ms;
    r = '0;
    if (t.year < EPOCH_YEAR || t.year > LAST_YEAR || t.month < 1 || t.month > 12 ||
        t.day < 1 || t.hour > 23 || t.minute > 59 || t.milli_of_minute > MS_PER_MIN_MAX) begin
      return r;
    end
    days = 0;
    for (yr = EPOCH_YEAR; yr < t.year; yr++) begin
      days += 365 + gregorian_leap(yr);
    end
    case (t.month)
      4'd1:    doy0 = 0;
      4'd2:    doy0 = 31;
      4'd3:    doy0 = 59;
      4'd4:    doy0 = 90;
      4'd5:    doy0 = 120;
      4'd6:    doy0 = 151;
      4'd7:    doy0 = 181;
      4'd8:    doy0 = 212;
      4'd9:    doy0 = 243;
      4'd10:   doy0 = 273;
      4'd11:   doy0 = 304;
      default: doy0 = 334;
    endcase
    if (t.month > 2 && gregorian_leap(t.year)) begin
      doy0 += 1;
    end
    doy0 += t.day - 1;
    days += doy0;
    ms = longint'(t.milli_of_minute) + longint'(t.minute) * MS_PER_MINUTE +
         longint'(t.hour) * MS_PER_HOUR + days * MS_PER_DAY;
    r.epoch_millis = ms[EPOCH_W-1:0];
    r.day_of_year  = DOY_W'(doy0 + 1);
    r.day_of_week  = DOW_W'(((days + 4) % 7) + 1);
    r.in_range     = 1'b1;
    return r;
  endfunction

  function automatic in_item_t civil_time(input int unsigned year, input int unsigned month,
                                          input int unsigned day, input int unsigned hour,
                                          input int unsigned minute, input int unsigned milli);
    in_item_t t;
    t.year            = YEAR_W'(year);
    t.month           = MONTH_W'(month);
    t.day             = DAY_W'(day);
    t.hour            = HOUR_W'(hour);
    t.minute          = MINUTE_W'(minute);
    t.milli_of_minute = MILLI_W'(milli);
    return t;
  endfunction

  function automatic in_item_t random_valid_time();
    int unsigned year;
    int unsigned day;
    case ($urandom_range(9, 0))
      0:       year = EPOCH_YEAR;
      1:       year = LAST_YEAR;
      2:       year = 2000;
      default: year = $urandom_range(LAST_YEAR, EPOCH_YEAR);
    endcase
    day = ($urandom_range(3, 0) == 0) ? $urandom_range(31, 28) : $urandom_range(31, 1);
    return civil_time(year, $urandom_range(12, 1), day, $urandom_range(23, 0),
                      $urandom_range(59, 0), $urandom_range(MS_PER_MIN_MAX, 0));
  endfunction

  function automatic in_item_t random_noise_time();
    in_item_t t;
    t = random_valid_time();
    case ($urandom_range(7, 0))
      0: t = in_item_t'({$urandom(), $urandom()});
      1: t.year = YEAR_W'(($urandom_range(1, 0) == 1) ? $urandom_range(EPOCH_YEAR - 1, 0)
                                                       : $urandom_range(4095, LAST_YEAR + 1));
      2: t.month = ($urandom_range(1, 0) == 1) ? 4'd0 : MONTH_W'($urandom_range(15, 13));
      3: t.day = '0;
      4: t.hour = HOUR_W'($urandom_range(31, 24));
      5: t.minute = MINUTE_W'($urandom_range(63, 60));
      default: t.milli_of_minute = MILLI_W'($urandom_range(65535, MS_PER_MINUTE));
    endcase
    return t;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned want,
                                 input longint unsigned got);
    $display("tb_top: mismatch in %s: expected %0d, got %0d", what, want, got);
    mismatch_count++;
  endtask

  task automatic send_civil_time(input in_item_t t);
    int unsigned gap;
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (sender_free || roll < 50) begin
      gap = 0;
    end else if (roll < 90) begin
      gap = $urandom_range(3, 1);
    end else begin
      gap = $urandom_range(40, 10);
    end
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= t;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_epoch_result(t));
  endtask

  always @(posedge clk) begin
    if (!rst_n || stall_free) begin
      out_tready <= 1'b1;
      ready_left <= 0;
    end else if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      ready_roll = $urandom_range(99, 0);
      if (ready_roll < 65) begin
        out_tready <= 1'b1;
        ready_left <= $urandom_range(20, 0);
      end else if (ready_roll < 95) begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(3, 0);
      end else begin
        out_tready <= 1'b0;
        ready_left <= $urandom_range(60, 20);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", 0, out_tdata[EPOCH_W-1:0]);
      end else begin
        expected_now = pending_results.pop_front();
        if (out_tdata[40:0] !== expected_now.epoch_millis) begin
          report_mismatch("epoch_millis", expected_now.epoch_millis, out_tdata[40:0]);
        end
        if (out_tdata[49:41] !== expected_now.day_of_year) begin
          report_mismatch("day_of_year", expected_now.day_of_year, out_tdata[49:41]);
        end
        if (out_tdata[52:50] !== expected_now.day_of_week) begin
          report_mismatch("day_of_week", expected_now.day_of_week, out_tdata[52:50]);
        end
        if (out_tdata[55:53] !== 3'd0) begin
          report_mismatch("zero fill", 0, out_tdata[55:53]);
        end
        if (out_tuser !== expected_now.in_range) begin
          report_mismatch("valid_res", expected_now.in_range, out_tuser);
        end
      end
    end
  end

  task automatic test_range_extremes();
    send_civil_time(civil_time(EPOCH_YEAR, 1, 1, 0, 0, 0));
    send_civil_time(civil_time(LAST_YEAR, 12, 31, 23, 59, MS_PER_MIN_MAX));
    send_civil_time(civil_time(EPOCH_YEAR, 1, 31, 23, 59, MS_PER_MIN_MAX));
    send_civil_time(civil_time(2000, 12, 31, 12, 30, 30000));
    send_civil_time(civil_time(2000, 2, 29, 0, 0, 1));
    send_civil_time(civil_time(2036, 12, 31, 23, 0, 0));
    send_civil_time(civil_time(LAST_YEAR, 1, 1, 0, 0, 0));
  endtask

  task automatic test_invalid_fields();
    send_civil_time(civil_time(EPOCH_YEAR - 1, 6, 15, 12, 30, 0));
    send_civil_time(civil_time(LAST_YEAR + 1, 6, 15, 12, 30, 0));
    send_civil_time(civil_time(0, 6, 15, 12, 30, 0));
    send_civil_time(civil_time(4095, 6, 15, 12, 30, 0));
    send_civil_time(civil_time(2010, 0, 15, 12, 30, 0));
    send_civil_time(civil_time(2010, 13, 15, 12, 30, 0));
    send_civil_time(civil_time(2010, 15, 15, 12, 30, 0));
    send_civil_time(civil_time(2010, 6, 0, 12, 30, 0));
    send_civil_time(civil_time(2010, 6, 15, 24, 30, 0));
    send_civil_time(civil_time(2010, 6, 15, 31, 30, 0));
    send_civil_time(civil_time(2010, 6, 15, 12, 60, 0));
    send_civil_time(civil_time(2010, 6, 15, 12, 63, 0));
    send_civil_time(civil_time(2010, 6, 15, 12, 30, MS_PER_MINUTE));
    send_civil_time(civil_time(2010, 6, 15, 12, 30, 65535));
  endtask

  task automatic test_day_overflow();
    send_civil_time(civil_time(LAST_YEAR, 2, 31, 1, 2, 3));
    send_civil_time(civil_time(2001, 2, 29, 0, 0, 0));
    send_civil_time(civil_time(2000, 2, 30, 0, 0, 0));
    send_civil_time(civil_time(1999, 4, 31, 23, 59, MS_PER_MIN_MAX));
  endtask

  task automatic test_random_times();
    int unsigned n;
    for (n = 0; n < 800; n++) begin
      sender_free <= ((n / 50) % 5 == 3);
      stall_free  <= ((n / 50) % 5 == 3);
      if ($urandom_range(99, 0) < 85) begin
        send_civil_time(random_valid_time());
      end else begin
        send_civil_time(random_noise_time());
      end
    end
    in_tvalid   <= 1'b0;
    sender_free <= 1'b0;
    stall_free  <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_range_extremes();
    test_invalid_fields();
    test_day_overflow();
    test_random_times();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule
